// ===== hdl/trwm_pkg.sv =====
package trwm_pkg;

   // Defaults for the top-level parameters
   localparam int GLYPH_SLOTS_DEF = 96;
   localparam int POS_BITS_DEF    = 24;

   // Field widths fixed by the interface
   localparam int CODE_BITS   = 8;
   localparam int GLYPH_BITS  = 8;
   localparam int START_BITS  = 24;
   localparam int WIDTH_BITS  = 16;
   localparam int HALF_BITS   = 7;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = HALF_BITS;

   // Advance operand: up to four times the half pitch
   localparam int ADD_BITS = HALF_BITS + 2;

   // Character codes
   localparam logic [CODE_BITS-1:0] FIRST_GLYPH_CODE = 8'h21;
   localparam logic [CODE_BITS-1:0] CODE_SPACE       = 8'h20;
   localparam logic [CODE_BITS-1:0] CODE_TAB         = 8'h09;

   // Tab stops every four half pitches, monospace advance two half pitches
   localparam int TAB_STOP_SHIFT = 2;
   localparam int MONO_SHIFT     = 1;

   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 16'hFFFF;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_PITCH = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MONOSPACE  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic wr_table;   // load transaction: write glyph table
      logic capture;    // measure transaction: latch fields, read table
      logic advance;    // main pen update, arm divider
      logic div_step;   // one remainder bit
      logic tab_apply;  // round pen up to the tab stop
      logic load_rsp;   // move run width into the output register
   } trwm_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_div;   // proportional-mode tab with a non-zero stop spacing
      logic last;       // current character closes the run
      logic div_done;   // final remainder bit this cycle
      logic rsp_free;   // output register can take a result
   } trwm_sts_type;

endpackage

// ===== hdl/trwm_ram.sv =====
module trwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 96,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/trwm_ctrl.sv =====
module trwm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_op,
   output logic                  req_stall,
   input  trwm_pkg::trwm_sts_type sts,
   output trwm_pkg::trwm_cmd_type cmd
);
   import trwm_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADV  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_TAB  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_op) state_in = S_ADV;
         end
         S_ADV: begin
            state_in = sts.need_div ? S_DIV : S_FIN;
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_TAB;
         end
         S_TAB: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!sts.last || sts.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command decode
   always_comb begin
      cmd           = '0;
      cmd.wr_table  = accept && !req_op;
      cmd.capture   = accept && req_op;
      cmd.advance   = (state_ff == S_ADV);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.tab_apply = (state_ff == S_TAB);
      cmd.load_rsp  = (state_ff == S_FIN) && sts.last && sts.rsp_free;
   end

endmodule

// ===== hdl/trwm_dp.sv =====
module trwm_dp #(
   parameter int GLYPH_SLOTS = trwm_pkg::GLYPH_SLOTS_DEF,
   parameter int POS_BITS    = trwm_pkg::POS_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [trwm_pkg::CODE_BITS-1:0]       req_char_code,
   input  logic [trwm_pkg::GLYPH_BITS-1:0]      req_glyph_width,
   input  logic signed [trwm_pkg::START_BITS-1:0] req_start_pos,
   input  logic                                 req_first_char,
   input  logic                                 req_last_char,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [trwm_pkg::WIDTH_BITS-1:0]      rsp_run_width,
   input  logic                                 csr_wr_en,
   input  logic [trwm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [trwm_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  trwm_pkg::trwm_cmd_type                cmd,
   output trwm_pkg::trwm_sts_type                sts
);
   import trwm_pkg::*;

   localparam int ADDR_BITS = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(POS_BITS + 1);

   // Configuration
   logic [HALF_BITS-1:0] half_ff;
   logic                 mono_ff;

   // Run state
   logic [POS_BITS-1:0]  pen_ff, pen_in;
   logic [POS_BITS-1:0]  origin_ff;
   logic [CODE_BITS-1:0] code_ff;
   logic                 last_ff;
   logic                 inrange_ff;

   // Remainder unit
   logic [POS_BITS-1:0]  quo_ff;
   logic [ADD_BITS-1:0]  rem_ff, rem_in;
   logic                 neg_ff;
   logic [CNT_BITS-1:0]  cnt_ff;

   // Output register
   logic                  rsp_valid_ff;
   logic [WIDTH_BITS-1:0] rsp_width_ff;

   logic [CODE_BITS-1:0]  req_idx;
   logic                  req_inrange;
   logic [GLYPH_BITS-1:0] glyph_rd;
   logic [ADD_BITS-1:0]   tab_span;
   logic [ADD_BITS-1:0]   tab_add;
   logic [ADD_BITS-1:0]   addend;
   logic [POS_BITS-1:0]   pen_sum;
   logic [POS_BITS-1:0]   pen_mag;
   logic [ADD_BITS:0]     rem_sh;
   logic [31:0]           start_ext;
   logic signed [POS_BITS:0] diff;
   logic [WIDTH_BITS-1:0] width_sat;

   // Table index and range check
   assign req_idx     = req_char_code - FIRST_GLYPH_CODE;
   assign req_inrange = (req_char_code >= FIRST_GLYPH_CODE) &&
                        ({1'b0, req_idx} < 9'(GLYPH_SLOTS));

   trwm_ram #(
      .WIDTH (GLYPH_BITS),
      .DEPTH (GLYPH_SLOTS),
      .ADDR_BITS (ADDR_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_table && req_inrange),
      .wr_addr (req_idx[ADDR_BITS-1:0]),
      .wr_data (req_glyph_width),
      .rd_en   (cmd.capture),
      .rd_addr (req_idx[ADDR_BITS-1:0]),
      .rd_data (glyph_rd)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= HALF_BITS'(8);
         mono_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HALF_PITCH: half_ff <= csr_wdata;
            CSR_MONOSPACE:  mono_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Tab stop spacing and the step up to the next stop
   assign tab_span = {half_ff, {TAB_STOP_SHIFT{1'b0}}};
   always_comb begin
      if (neg_ff) begin
         tab_add = rem_ff;
      end else if (rem_ff == '0) begin
         tab_add = '0;
      end else begin
         tab_add = tab_span - rem_ff;
      end
   end

   // Advance selection
   always_comb begin
      if (cmd.tab_apply) begin
         addend = tab_add;
      end else if (mono_ff) begin
         addend = ADD_BITS'({half_ff, {MONO_SHIFT{1'b0}}});
      end else if (code_ff == CODE_SPACE) begin
         addend = ADD_BITS'(half_ff);
      end else if (code_ff == CODE_TAB) begin
         addend = ADD_BITS'(1);
      end else if (inrange_ff) begin
         addend = ADD_BITS'(glyph_rd);
      end else begin
         addend = '0;
      end
   end

   assign pen_sum   = pen_ff + POS_BITS'(addend);
   assign pen_mag   = pen_sum[POS_BITS-1] ? (~pen_sum + POS_BITS'(1)) : pen_sum;
   assign start_ext = {{(32-START_BITS){req_start_pos[START_BITS-1]}}, req_start_pos};

   // Pen and origin
   always_comb begin
      pen_in = pen_ff;
      if (cmd.capture && req_first_char) begin
         pen_in = start_ext[POS_BITS-1:0];
      end else if (cmd.advance || cmd.tab_apply) begin
         pen_in = pen_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff    <= '0;
         origin_ff <= '0;
      end else begin
         pen_ff <= pen_in;
         if (cmd.capture && req_first_char) begin
            origin_ff <= start_ext[POS_BITS-1:0];
         end
      end
   end

   // Character fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff    <= req_char_code;
         last_ff    <= req_last_char;
         inrange_ff <= req_inrange;
      end
   end

   // Restoring remainder of |pen| by the tab spacing, one bit per cycle
   assign rem_sh = {rem_ff, quo_ff[POS_BITS-1]};
   always_comb begin
      if (rem_sh >= {1'b0, tab_span}) begin
         rem_in = ADD_BITS'(rem_sh - {1'b0, tab_span});
      end else begin
         rem_in = rem_sh[ADD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.advance) begin
         cnt_ff <= CNT_BITS'(POS_BITS);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         quo_ff <= pen_mag;
         rem_ff <= '0;
         neg_ff <= pen_sum[POS_BITS-1];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[POS_BITS-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   // Run width, clamped to the result range
   assign diff = $signed({pen_ff[POS_BITS-1], pen_ff}) -
                 $signed({origin_ff[POS_BITS-1], origin_ff});
   always_comb begin
      if (diff < 0) begin
         width_sat = '0;
      end else if (diff > $signed((POS_BITS+1)'(WIDTH_MAX))) begin
         width_sat = WIDTH_MAX;
      end else begin
         width_sat = diff[WIDTH_BITS-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_width_ff <= width_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_width = rsp_width_ff;

   // Status
   assign sts.need_div = !mono_ff && (code_ff == CODE_TAB) && (half_ff != '0);
   assign sts.last     = last_ff;
   assign sts.div_done = (cnt_ff == CNT_BITS'(1));
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== hdl/text_run_width_measure_unit.sv =====
// Text run width measurement.
// Request channel (req_valid / req_stall): a load transaction (op 0) writes one
// glyph advance into the table at char_code-0x21; a measure transaction (op 1)
// moves the pen by one character and, with last_char set, produces a run width.
// Response channel (rsp_valid / rsp_stall) carries the width, clamped to
// 0..65535. The csr_ port writes the half pitch (index 0) and monospace (index
// 1); write it only while the block is idle, which the block does not enforce.
// Load transactions leave req_stall low.
// A measure transaction holds req_stall high through the pen update (S_ADV) and
// the result stage (S_FIN), so a new request waits until the measure is done.
// A tab in proportional mode with a non-zero half pitch adds the S_DIV and S_TAB
// states; the restoring unit forms the tab-spacing remainder one bit per cycle.
// The run width is loaded into the output register in the result stage, which
// raises rsp_valid.
// The result sits in an output register; new requests are taken while it
// waits. A further closing character stalls only if the register is still full.
// Reset clears the pen, origin, output and controller, and sets the half pitch
// to 8 and monospace to 0. The glyph table is not cleared; unwritten entries are
// undefined.
module text_run_width_measure_unit #(
   parameter int GLYPH_SLOTS = trwm_pkg::GLYPH_SLOTS_DEF,
   parameter int POS_BITS    = trwm_pkg::POS_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic [trwm_pkg::CODE_BITS-1:0]         req_char_code,
   input  logic [trwm_pkg::GLYPH_BITS-1:0]        req_glyph_width,
   input  logic signed [trwm_pkg::START_BITS-1:0] req_start_pos,
   input  logic                                   req_first_char,
   input  logic                                   req_last_char,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [trwm_pkg::WIDTH_BITS-1:0]        rsp_run_width,
   input  logic                                   csr_wr_en,
   input  logic [trwm_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [trwm_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import trwm_pkg::*;

   trwm_cmd_type cmd;
   trwm_sts_type sts;

   trwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   trwm_dp #(
      .GLYPH_SLOTS (GLYPH_SLOTS),
      .POS_BITS    (POS_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_char_code   (req_char_code),
      .req_glyph_width (req_glyph_width),
      .req_start_pos   (req_start_pos),
      .req_first_char  (req_first_char),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_run_width   (rsp_run_width),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

// ===== hdl/trwm_chk.sv =====
module trwm_chk (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   req_op,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [trwm_pkg::WIDTH_BITS-1:0]        rsp_run_width
);

   // Reset leaves no result pending and the input open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("state not cleared by reset");

   // A measure transaction occupies the block on the following cycle
   a_measure_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op) |=> req_stall)
      else $error("measure transaction did not occupy the block");

   // A table load completes in its own cycle
   a_load_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_op) |=> !req_stall)
      else $error("load transaction stalled the input");

   // A new result only follows a cycle of measurement work
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without a measure in progress");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_run_width)))
      else $error("stalled response changed");

endmodule

bind text_run_width_measure_unit trwm_chk u_trwm_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_run_width (rsp_run_width)
);

// ===== sim/text_run_width_measure_unit_test.sv =====
module text_run_width_measure_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import trwm_pkg::*;

   localparam int SLOTS          = GLYPH_SLOTS_DEF;
   localparam int PBITS          = POS_BITS_DEF;
   localparam int SETTLE_CYCLES  = PBITS + 16;   // longest latency is a closing tab
   localparam int LONG_HOLD      = 300;
   localparam int ITEM_TARGET    = 950;
   localparam int END_WAIT_LIMIT = 20000;
   localparam int RUN_LIMIT_NS   = 5_000_000;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_MEASURE = 1'b1
   } char_op_type;

   typedef struct {
      char_op_type                  op;
      logic [CODE_BITS-1:0]         char_code;
      logic [GLYPH_BITS-1:0]        glyph;
      logic signed [START_BITS-1:0] start_pos;
      logic                         first_char;
      logic                         last_char;
   } char_txn_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_op;
   logic [CODE_BITS-1:0]         req_char_code;
   logic [GLYPH_BITS-1:0]        req_glyph_width;
   logic signed [START_BITS-1:0] req_start_pos;
   logic                         req_first_char;
   logic                         req_last_char;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [WIDTH_BITS-1:0]        rsp_run_width;
   logic                         csr_wr_en;
   logic [CSR_IDX_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0]     csr_wdata;

   // Predictor state
   logic [GLYPH_BITS-1:0] advance_mem [SLOTS];
   bit                    slot_loaded [SLOTS];
   longint                pen_x;
   longint                origin_x;
   longint                half_w;
   bit                    mono_mode;
   logic [WIDTH_BITS-1:0] width_queue [$];

   // Bookkeeping
   int  mismatch_count;
   int  widths_checked;
   int  items_counted;
   int  measures_sent;
   int  loads_sent;
   int  config_settings;
   int  burst_left;
   bit  pacing_on;
   bit  hold_pending;

   text_run_width_measure_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_char_code   (req_char_code),
      .req_glyph_width (req_glyph_width),
      .req_start_pos   (req_start_pos),
      .req_first_char  (req_first_char),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_run_width   (rsp_run_width),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Pen position predictor
   // ---------------------------------------------------------------------

   // Two's complement wrap to the pen width
   function automatic longint wrap_pen(input longint v);
      logic signed [PBITS-1:0] t;
      t = v[PBITS-1:0];
      return t;
   endfunction

   // Apply one accepted transaction; a closing character queues its width
   function automatic void predict_char(input char_txn_type t);
      int     slot;
      longint pos;
      longint stop;
      longint rem;
      longint w;
      slot = int'(t.char_code) - int'(FIRST_GLYPH_CODE);
      if (t.op == OP_LOAD) begin
         if (slot >= 0 && slot < SLOTS) begin
            advance_mem[slot] = t.glyph;
            slot_loaded[slot] = 1'b1;
         end
         return;
      end
      if (t.first_char) begin
         pen_x    = wrap_pen(longint'(t.start_pos));
         origin_x = pen_x;
      end
      pos = pen_x;
      if (mono_mode) begin
         pos = pos + 2 * half_w;
      end else if (t.char_code == CODE_SPACE) begin
         pos = pos + half_w;
      end else if (t.char_code == CODE_TAB) begin
         stop = 4 * half_w;
         pos  = wrap_pen(pos + 1);
         if (stop > 0) begin
            rem = pos % stop;
            if (rem < 0) rem = rem + stop;
            if (rem != 0) pos = pos + stop - rem;
         end
      end else if (slot >= 0 && slot < SLOTS) begin
         pos = pos + longint'(advance_mem[slot]);
      end
      pen_x = wrap_pen(pos);
      if (t.last_char) begin
         w = pen_x - origin_x;
         if (w < 0) w = 0;
         if (w > longint'(WIDTH_MAX)) w = longint'(WIDTH_MAX);
         width_queue.push_back(w[WIDTH_BITS-1:0]);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Transaction builders and random content
   // ---------------------------------------------------------------------

   function automatic char_txn_type measure_txn(input logic [CODE_BITS-1:0] code,
                                                input logic signed [START_BITS-1:0] start,
                                                input logic first, input logic last);
      char_txn_type t;
      t.op         = OP_MEASURE;
      t.char_code  = code;
      t.glyph      = GLYPH_BITS'($urandom);
      t.start_pos  = start;
      t.first_char = first;
      t.last_char  = last;
      return t;
   endfunction

   // Flags and start position are don't-care on a load, so randomise them
   function automatic char_txn_type load_txn(input logic [CODE_BITS-1:0] code,
                                             input logic [GLYPH_BITS-1:0] glyph);
      char_txn_type t;
      t.op         = OP_LOAD;
      t.char_code  = code;
      t.glyph      = glyph;
      t.start_pos  = START_BITS'($urandom);
      t.first_char = 1'($urandom_range(0, 1));
      t.last_char  = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic logic signed [START_BITS-1:0] pick_start();
      int v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = 32'h007F_FFFF - $urandom_range(0, 600);
         2: v = 32'hFF80_0000 + $urandom_range(0, 600);
         default: v = $urandom_range(0, 4000) - 2000;
      endcase
      return START_BITS'(v);
   endfunction

   // Table codes are only drawn from slots that hold a written width
   function automatic logic [CODE_BITS-1:0] pick_code();
      int sel;
      int slot;
      sel = $urandom_range(0, 99);
      if (sel < 12) return CODE_SPACE;
      if (sel < 24) return CODE_TAB;
      if (sel < 32) begin
         case ($urandom_range(0, 2))
            0: return CODE_BITS'($urandom_range(0, 8));
            1: return CODE_BITS'($urandom_range(10, 31));
            default: return CODE_BITS'($urandom_range(int'(FIRST_GLYPH_CODE) + SLOTS, 255));
         endcase
      end
      slot = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
         if (slot_loaded[(slot + k) % SLOTS])
            return CODE_BITS'(int'(FIRST_GLYPH_CODE) + (slot + k) % SLOTS);
      end
      return CODE_SPACE;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Random gaps between bursts of back-to-back transactions
   task automatic pace();
      int gap;
      if (!pacing_on) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 3);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic send_char(input char_txn_type t);
      int slot;
      req_valid       <= 1'b1;
      req_op          <= t.op;
      req_char_code   <= t.char_code;
      req_glyph_width <= t.glyph;
      req_start_pos   <= t.start_pos;
      req_first_char  <= t.first_char;
      req_last_char   <= t.last_char;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_char(t);
      slot = int'(t.char_code) - int'(FIRST_GLYPH_CODE);
      if (t.op == OP_MEASURE) begin
         measures_sent++;
         items_counted++;
      end else begin
         loads_sent++;
         if (slot >= 0 && slot < SLOTS) items_counted++;
      end
      pace();
   endtask

   // Let all expected widths arrive and any trailing work finish
   task automatic drain();
      req_valid <= 1'b0;
      while (width_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers are written back to back while the block is idle
   task automatic configure(input int hw, input bit mono);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HALF_PITCH;
      csr_wdata <= CSR_DATA_BITS'(hw);
      @(posedge clock);
      half_w    = hw;
      csr_index <= CSR_MONOSPACE;
      csr_wdata <= CSR_DATA_BITS'(mono);
      @(posedge clock);
      mono_mode = mono;
      csr_wr_en <= 1'b0;
      config_settings++;
   endtask

   // A run of measure transactions with occasional table loads mixed in, optionally with its marks dropped
   task automatic send_run(input int len, input bit with_first, input bit with_last);
      logic signed [START_BITS-1:0] start;
      char_txn_type t;
      start = pick_start();
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_char(load_txn(CODE_BITS'(int'(FIRST_GLYPH_CODE) + $urandom_range(0, SLOTS - 1)),
                               GLYPH_BITS'($urandom)));
         t = measure_txn(pick_code(), (i == 0) ? start : START_BITS'($urandom),
                         with_first && i == 0, with_last && i == len - 1);
         send_char(t);
      end
   endtask

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------

   // Pen and origin left at zero by reset, default half pitch
   task automatic test_reset_carry();
      send_char(measure_txn(CODE_SPACE, START_BITS'($urandom), 1'b0, 1'b1));
   endtask

   // First, last and beyond-table slots; ignored loads carry random flags
   task automatic test_table_limits();
      send_char(load_txn(FIRST_GLYPH_CODE, 8'h00));
      send_char(load_txn(FIRST_GLYPH_CODE + 8'd1, 8'hFF));
      send_char(load_txn(CODE_BITS'(int'(FIRST_GLYPH_CODE) + SLOTS - 1), 8'hAA));
      send_char(load_txn(CODE_BITS'(int'(FIRST_GLYPH_CODE) + SLOTS), 8'h55));
      send_char(load_txn(8'h00, 8'hFF));
      send_char(load_txn(8'hFF, 8'h77));
      send_char(measure_txn(FIRST_GLYPH_CODE, 24'sd0, 1'b1, 1'b0));
      send_char(measure_txn(FIRST_GLYPH_CODE + 8'd1, 24'sd0, 1'b0, 1'b0));
      send_char(measure_txn(CODE_BITS'(int'(FIRST_GLYPH_CODE) + SLOTS), 24'sd0, 1'b0, 1'b0));
      send_char(measure_txn(8'h00, 24'sd0, 1'b0, 1'b0));
      send_char(measure_txn(8'hFF, 24'sd0, 1'b0, 1'b0));
      send_char(measure_txn(CODE_BITS'(int'(FIRST_GLYPH_CODE) + SLOTS - 1), 24'sd0,
                            1'b0, 1'b1));
   endtask

   // Tabs from the most negative start, from just below a stop and from -1
   task automatic test_space_and_tab();
      send_char(measure_txn(CODE_SPACE, 24'sh800000, 1'b1, 1'b0));
      send_char(measure_txn(CODE_TAB, 24'sd0, 1'b0, 1'b0));
      send_char(measure_txn(CODE_TAB, 24'sd0, 1'b0, 1'b1));
      send_char(measure_txn(CODE_TAB, 24'sd31, 1'b1, 1'b1));
      send_char(measure_txn(CODE_TAB, -24'sd1, 1'b1, 1'b1));
   endtask

   // Pen wraps past the top, so the width comes out negative and clamps
   task automatic test_pen_wrap();
      send_char(measure_txn(FIRST_GLYPH_CODE + 8'd1, 24'sh7FFFFF, 1'b1, 1'b1));
      send_char(measure_txn(CODE_TAB, 24'sh7FFFF0, 1'b1, 1'b1));
   endtask

   task automatic test_zero_half_width();
      configure(0, 1'b0);
      send_char(measure_txn(CODE_SPACE, 24'sd5, 1'b1, 1'b0));
      send_char(measure_txn(CODE_TAB, 24'sd0, 1'b0, 1'b0));
      send_char(measure_txn(FIRST_GLYPH_CODE + 8'd1, 24'sd0, 1'b0, 1'b1));
      configure(0, 1'b1);
      send_char(measure_txn(FIRST_GLYPH_CODE + 8'd1, -24'sd3, 1'b1, 1'b1));
   endtask

   task automatic test_monospace();
      configure(127, 1'b1);
      send_char(measure_txn(CODE_SPACE, 24'sd1000, 1'b1, 1'b0));
      send_char(measure_txn(CODE_TAB, 24'sd0, 1'b0, 1'b0));
      send_char(measure_txn(8'h00, 24'sd0, 1'b0, 1'b1));
   endtask

   // Wide tab stops push the width past 16 bits
   task automatic test_width_saturation();
      configure(127, 1'b0);
      for (int i = 0; i < 140; i++)
         send_char(measure_txn(CODE_TAB, START_BITS'($urandom_range(0, 1000)),
                               i == 0, i == 139));
   endtask

   // Receiver holds off while closing characters keep coming
   task automatic test_output_backpressure();
      configure(8, 1'b0);
      pacing_on    = 1'b0;
      hold_pending = 1'b1;
      for (int i = 0; i < 24; i++)
         send_char(measure_txn(pick_code(), pick_start(), 1'b1, 1'b1));
      pacing_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Random traffic over a series of register settings
   // ---------------------------------------------------------------------
   task automatic test_random_traffic();
      int phase;
      int phase_end;
      int sel;
      char_txn_type t;
      phase = 0;
      while (items_counted < ITEM_TARGET) begin
         case (phase % 8)
            0: configure(8, 1'b0);
            1: configure(127, 1'b0);
            2: configure(1, 1'b0);
            3: configure(0, 1'b0);
            4: configure(127, 1'b1);
            5: configure(1, 1'b1);
            default: configure($urandom_range(0, 127), 1'($urandom_range(0, 1)));
         endcase
         phase_end = items_counted + 95;
         while (items_counted < phase_end && items_counted < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 62) begin
               send_run(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 12), 1'b1, 1'b1);
            end else if (sel < 70) begin
               send_run($urandom_range(1, 6), 1'b0, 1'b1);
            end else if (sel < 75) begin
               send_run($urandom_range(1, 6), 1'b1, 1'b0);
            end else if (sel < 88) begin
               repeat ($urandom_range(1, 4))
                  send_char(load_txn(CODE_BITS'(int'(FIRST_GLYPH_CODE)
                                                + $urandom_range(0, SLOTS - 1)),
                                     GLYPH_BITS'($urandom)));
            end else begin
               // Noise: loose flags, any code on loads
               if ($urandom_range(0, 1) == 0)
                  t = load_txn(CODE_BITS'($urandom), GLYPH_BITS'($urandom));
               else
                  t = measure_txn(pick_code(), START_BITS'($urandom),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
               send_char(t);
            end
         end
         phase++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Compare each accepted width with the oldest expectation
   always @(posedge clock) begin : width_check
      logic [WIDTH_BITS-1:0] want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (width_queue.size() == 0) begin
            note_mismatch("unexpected run width", -1, int'(rsp_run_width));
         end else begin
            want = width_queue.pop_front();
            if (rsp_run_width !== want)
               note_mismatch("run width", int'(want), int'(rsp_run_width));
         end
         widths_checked++;
      end
   end

   // Receiver stall pattern, with one long hold-off on request
   initial begin : stall_pattern
      int stall_mode;
      int stall_run;
      int hold_count;
      stall_mode = 0;
      stall_run  = 0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            hold_count = 0;
            while (hold_count < LONG_HOLD) begin
               @(posedge clock);
               hold_count++;
            end
         end
         if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(8, 80);
         end
         stall_run--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= stall_run[0];
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : test_sequence
      int waited;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_LOAD;
      req_char_code   = '0;
      req_glyph_width = '0;
      req_start_pos   = '0;
      req_first_char  = 1'b0;
      req_last_char   = 1'b0;
      rsp_stall       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_HALF_PITCH;
      csr_wdata       = '0;
      pen_x           = 0;
      origin_x        = 0;
      half_w          = 8;
      mono_mode       = 1'b0;
      mismatch_count  = 0;
      widths_checked  = 0;
      items_counted   = 0;
      measures_sent   = 0;
      loads_sent      = 0;
      config_settings = 0;
      burst_left      = 0;
      pacing_on       = 1'b1;
      hold_pending    = 1'b0;
      for (int i = 0; i < SLOTS; i++) slot_loaded[i] = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_carry();
      test_table_limits();
      test_space_and_tab();
      test_pen_wrap();
      test_zero_half_width();
      test_monospace();
      test_width_saturation();
      test_output_backpressure();
      test_random_traffic();

      // Wind down, bounded, then settle
      req_valid <= 1'b0;
      waited = 0;
      while (width_queue.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (width_queue.size() != 0) begin
         $display("%0d run widths never arrived", width_queue.size());
         mismatch_count += width_queue.size();
      end

      $display("Covered %0d measure and %0d load transactions over %0d register settings.",
               measures_sent, loads_sent, config_settings);
      $display("Checked %0d run widths; %0d failed.", widths_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d run widths outstanding", width_queue.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/trwm_pkg.sv
hdl/trwm_ram.sv
hdl/trwm_ctrl.sv
hdl/trwm_dp.sv
hdl/text_run_width_measure_unit.sv
hdl/trwm_chk.sv
sim/text_run_width_measure_unit_test.sv
